### rtl/mtw_pkg.sv
// ----------------------------------------------------------------------------
// mtw_pkg
// Shared types and constants for the multi-task watchdog.
// ----------------------------------------------------------------------------
package mtw_pkg;

    localparam int NUM_TASKS = 8;
    localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W     = 20;
    localparam int PERIOD_W  = 16;
    localparam int TASK_ID_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    localparam logic [CNT_W-1:0]    CNT_MAX             = '1;
    localparam logic [PERIOD_W-1:0] CHECK_PERIOD_RST    = PERIOD_W'(300);
    localparam logic [CNT_W-1:0]    TASK_TIMEOUT_RST    = CNT_W'(30000);
    localparam logic [CNT_W-1:0]    STARTUP_TIMEOUT_RST = CNT_W'(240000);

    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_KICK_ONE  = 2'd1,
        REQ_KICK_ALL  = 2'd2,
        REQ_START_DONE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_STARTUP = 2'd1,
        CAUSE_TASK    = 2'd2
    } cause_t;

    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PERIOD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_TIMEOUT    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_TIMEOUT = CFG_IDX_W'(2);

    typedef struct packed {
        req_t                 req_type;
        logic [TASK_ID_W-1:0] task_id;
    } in_item_t;

    typedef struct packed {
        logic       pin_level;
        logic       reset_request;
        cause_t     reset_cause;
        logic [2:0] expired_task;
    } out_item_t;

    // priority link handed from cell to cell: first expired task so far
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } link_t;

endpackage

### rtl/mtw_task_cell.sv
// ----------------------------------------------------------------------------
// mtw_task_cell
// One task slot: saturating elapsed counter, timeout compare and a link of
// the lowest-index priority chain.
// ----------------------------------------------------------------------------
module mtw_task_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        count,
    input  logic                        clear,
    input  logic [mtw_pkg::CNT_W-1:0]   timeout,
    input  logic [mtw_pkg::IDX_W-1:0]   cell_index,
    input  mtw_pkg::link_t              link_in,
    output mtw_pkg::link_t              link_out
);

    logic [mtw_pkg::CNT_W-1:0] elapsed_reg;
    logic [mtw_pkg::CNT_W-1:0] elapsed_next;
    logic                      hit;

    always_comb
    begin
        elapsed_next = elapsed_reg;
        if (clear)
        begin
            elapsed_next = '0;
        end
        else if (count && (elapsed_reg != mtw_pkg::CNT_MAX))
        begin
            elapsed_next = elapsed_reg + mtw_pkg::CNT_W'(1);
        end
    end

    // compare against the post-tick value, as the check sees it
    assign hit = (elapsed_next >= timeout);

    always_comb
    begin
        link_out.found = link_in.found | hit;
        link_out.idx   = link_in.found ? link_in.idx : cell_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

### rtl/multi_task_watchdog_top.sv
// ----------------------------------------------------------------------------
// multi_task_watchdog_top
// Multi-task watchdog: per-task elapsed counters in a row of cells, startup
// timer, periodic health check, kick pin and latched reset request.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+-------------------
//  in      | in_valid, in_ready, in_item      | input     | req_type, task_id
//  out     | out_valid, out_ready, out_item   | output    | pin, reset status
//  cfg     | cfg_valid, cfg_ready, cfg_index, | input     | register write
//          | cfg_data                         |           |
//
//  One item per cycle while out_ready allows it; each item is done in the cycle
//  it is accepted and its result shows on out_item the next cycle. The timeout
//  compare and the priority chain through all task cells settle in that cycle.
//  in_ready follows out_ready while a result is held; cfg_ready is always high.
//  Reset loads the default register values and clears all counters.
// ----------------------------------------------------------------------------
module multi_task_watchdog_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mtw_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mtw_pkg::out_item_t                out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mtw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mtw_pkg::CFG_DAT_W-1:0]     cfg_data
);

    logic [mtw_pkg::PERIOD_W-1:0] check_period_reg;
    logic [mtw_pkg::CNT_W-1:0]    task_timeout_reg;
    logic [mtw_pkg::CNT_W-1:0]    startup_timeout_reg;

    logic [mtw_pkg::CNT_W-1:0]    startup_reg;
    logic [mtw_pkg::CNT_W-1:0]    startup_next;
    logic [mtw_pkg::PERIOD_W-1:0] check_count_reg;
    logic [mtw_pkg::PERIOD_W-1:0] check_count_inc;
    logic [mtw_pkg::PERIOD_W-1:0] check_count_next;
    logic                         starting_reg;
    logic                         starting_next;
    logic                         pin_reg;
    logic                         pin_next;
    logic                         latched_reg;
    logic                         latched_next;
    mtw_pkg::cause_t              cause_reg;
    mtw_pkg::cause_t              cause_next;
    logic [2:0]                   expired_reg;
    logic [2:0]                   expired_next;
    logic                         out_valid_reg;

    logic                         in_fire;
    logic                         tick;
    logic                         kick_one;
    logic                         kick_all;
    logic                         check_due;
    logic                         check_fail;
    logic [mtw_pkg::NUM_TASKS-1:0] cell_clear;
    mtw_pkg::link_t               links [0:mtw_pkg::NUM_TASKS];

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        tick     = 1'b0;
        kick_one = 1'b0;
        kick_all = 1'b0;
        unique case (in_item.req_type)
            mtw_pkg::REQ_TICK:       tick     = in_fire;
            mtw_pkg::REQ_KICK_ONE:   kick_one = in_fire;
            mtw_pkg::REQ_KICK_ALL:   kick_all = in_fire;
            mtw_pkg::REQ_START_DONE: ;
            default: ;
        endcase
    end

    assign links[0] = '0;

    for (genvar i = 0; i < mtw_pkg::NUM_TASKS; i++)
    begin : g_cell
        assign cell_clear[i] = kick_all ||
                               (kick_one && (32'(in_item.task_id) == i));

        mtw_task_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .count      (tick),
            .clear      (cell_clear[i]),
            .timeout    (task_timeout_reg),
            .cell_index (mtw_pkg::IDX_W'(i)),
            .link_in    (links[i]),
            .link_out   (links[i+1])
        );
    end

    always_comb
    begin
        startup_next = startup_reg;
        if (tick && (startup_reg != mtw_pkg::CNT_MAX))
        begin
            startup_next = startup_reg + mtw_pkg::CNT_W'(1);
        end

        check_count_inc  = check_count_reg + mtw_pkg::PERIOD_W'(1);
        check_due        = tick && (check_count_inc >= check_period_reg);
        check_count_next = check_count_reg;
        if (tick)
        begin
            check_count_next = check_due ? '0 : check_count_inc;
        end

        check_fail = starting_reg ? (startup_next > startup_timeout_reg)
                                  : links[mtw_pkg::NUM_TASKS].found;

        starting_next = starting_reg;
        pin_next      = pin_reg;
        latched_next  = latched_reg;
        cause_next    = cause_reg;
        expired_next  = expired_reg;

        if (in_fire && (in_item.req_type == mtw_pkg::REQ_START_DONE))
        begin
            starting_next = 1'b0;
            pin_next      = !pin_reg;
        end
        if (kick_all)
        begin
            pin_next = !pin_reg;
        end
        if (check_due && !latched_reg)
        begin
            if (check_fail)
            begin
                latched_next = 1'b1;
                if (starting_reg)
                begin
                    cause_next   = mtw_pkg::CAUSE_STARTUP;
                    expired_next = '0;
                end
                else
                begin
                    cause_next   = mtw_pkg::CAUSE_TASK;
                    expired_next = 3'(links[mtw_pkg::NUM_TASKS].idx);
                end
            end
            else
            begin
                pin_next = !pin_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_period_reg    <= mtw_pkg::CHECK_PERIOD_RST;
            task_timeout_reg    <= mtw_pkg::TASK_TIMEOUT_RST;
            startup_timeout_reg <= mtw_pkg::STARTUP_TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mtw_pkg::CFG_CHECK_PERIOD:
                    check_period_reg <= cfg_data[mtw_pkg::PERIOD_W-1:0];
                mtw_pkg::CFG_TASK_TIMEOUT:
                    task_timeout_reg <= cfg_data[mtw_pkg::CNT_W-1:0];
                mtw_pkg::CFG_STARTUP_TIMEOUT:
                    startup_timeout_reg <= cfg_data[mtw_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            startup_reg     <= '0;
            check_count_reg <= '0;
            starting_reg    <= 1'b1;
            pin_reg         <= 1'b1;
            latched_reg     <= 1'b0;
            cause_reg       <= mtw_pkg::CAUSE_NONE;
            expired_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            startup_reg     <= startup_next;
            check_count_reg <= check_count_next;
            starting_reg    <= starting_next;
            pin_reg         <= pin_next;
            latched_reg     <= latched_next;
            cause_reg       <= cause_next;
            expired_reg     <= expired_next;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // state registers change only on an accepted item, so they are the result
    always_comb
    begin
        out_item.pin_level     = pin_reg;
        out_item.reset_request = latched_reg;
        out_item.reset_cause   = cause_reg;
        out_item.expired_task  = expired_reg;
    end

    a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        latched_reg |=> latched_reg)
        else $error("reset request dropped");

    a_cause_matches_latch: assert property (@(posedge clk) disable iff (!rst_n)
        latched_reg == (cause_reg != mtw_pkg::CAUSE_NONE))
        else $error("reset cause inconsistent with latch");

    a_expired_only_task: assert property (@(posedge clk) disable iff (!rst_n)
        (expired_reg != 3'd0) |-> (cause_reg == mtw_pkg::CAUSE_TASK))
        else $error("expired task set without task cause");

    a_pin_quiet_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && !check_due) |=> $stable(pin_reg))
        else $error("pin toggled on a tick without a check");

    a_no_state_change_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> ($stable(pin_reg) && $stable(startup_reg)))
        else $error("state changed without an accepted item");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-task watchdog. A planner builds request
// streams that keep every task alive just short of its timeout, while an
// in-bench status model predicts pin level and reset latch for each item.
// Runs end on a startup timeout, a task reaching its timeout, or a zero task
// timeout, chosen at random, then continue past the latch.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [mtw_pkg::CFG_IDX_W-1:0] REG_SPARE = mtw_pkg::CFG_IDX_W'(3);

    typedef enum int {
        END_STARTUP   = 0,
        END_TASK_HIT  = 1,
        END_ZERO_TIME = 2
    } ending_t;

    typedef struct packed {
        logic [mtw_pkg::PERIOD_W-1:0]                      period;
        logic [mtw_pkg::CNT_W-1:0]                         task_to;
        logic [mtw_pkg::CNT_W-1:0]                         start_to;
        logic [mtw_pkg::NUM_TASKS-1:0][mtw_pkg::CNT_W-1:0] elapsed;
        logic [mtw_pkg::CNT_W-1:0]                         start_el;
        logic [mtw_pkg::PERIOD_W-1:0]                      chk_cnt;
        logic                                              starting;
        logic                                              pin;
        logic                                              latched;
        mtw_pkg::cause_t                                   cause;
        logic [2:0]                                        expired;
    } wd_state_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    mtw_pkg::in_item_t             in_item = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b1;
    mtw_pkg::out_item_t            out_item;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [mtw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mtw_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    wd_state_t           dut_model;      // advanced at each accepted item
    wd_state_t           plan_model;     // advanced as items are queued
    mtw_pkg::in_item_t   req_queue[$];
    mtw_pkg::out_item_t  status_queue[$];
    bit                  in_taken = 1'b0;
    bit                  cfg_taken = 1'b0;
    bit                  quiet = 1'b0;
    int                  in_gap = 0;
    int                  stall_left = 0;
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    ending_t             ending;

    multi_task_watchdog_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic wd_state_t watchdog_reset();
        wd_state_t s;
        s          = '0;
        s.period   = mtw_pkg::CHECK_PERIOD_RST;
        s.task_to  = mtw_pkg::TASK_TIMEOUT_RST;
        s.start_to = mtw_pkg::STARTUP_TIMEOUT_RST;
        s.starting = 1'b1;
        s.pin      = 1'b1;
        s.cause    = mtw_pkg::CAUSE_NONE;
        return s;
    endfunction

    function automatic wd_state_t apply_register(wd_state_t s,
                                                 logic [mtw_pkg::CFG_IDX_W-1:0] idx,
                                                 logic [mtw_pkg::CFG_DAT_W-1:0] val);
        case (idx)
            mtw_pkg::CFG_CHECK_PERIOD:    s.period   = val[mtw_pkg::PERIOD_W-1:0];
            mtw_pkg::CFG_TASK_TIMEOUT:    s.task_to  = val;
            mtw_pkg::CFG_STARTUP_TIMEOUT: s.start_to = val;
            default:                      ;
        endcase
        return s;
    endfunction

    function automatic wd_state_t watchdog_next(wd_state_t s, mtw_pkg::in_item_t it);
        int  i;
        int  lowest;
        bit  hit;
        hit    = 1'b0;
        lowest = 0;
        case (it.req_type)
            mtw_pkg::REQ_TICK:
            begin
                for (i = 0; i < mtw_pkg::NUM_TASKS; i++)
                    if (s.elapsed[i] != mtw_pkg::CNT_MAX)
                        s.elapsed[i] = s.elapsed[i] + 1'b1;
                if (s.start_el != mtw_pkg::CNT_MAX)
                    s.start_el = s.start_el + 1'b1;
                s.chk_cnt = s.chk_cnt + 1'b1;
                if (s.chk_cnt >= s.period)
                begin
                    s.chk_cnt = '0;
                    if (!s.latched)
                    begin
                        if (s.starting)
                            hit = (s.start_el > s.start_to);
                        else
                            // scan downward so the lowest expired task wins
                            for (i = mtw_pkg::NUM_TASKS - 1; i >= 0; i--)
                                if (s.elapsed[i] >= s.task_to)
                                begin
                                    hit    = 1'b1;
                                    lowest = i;
                                end
                        if (hit)
                        begin
                            s.latched = 1'b1;
                            s.cause   = s.starting ? mtw_pkg::CAUSE_STARTUP
                                                   : mtw_pkg::CAUSE_TASK;
                            s.expired = s.starting ? 3'd0 : 3'(lowest);
                        end
                        else
                            s.pin = ~s.pin;
                    end
                end
            end
            mtw_pkg::REQ_KICK_ONE:
                if (it.task_id < mtw_pkg::NUM_TASKS)
                    s.elapsed[it.task_id] = '0;
            mtw_pkg::REQ_KICK_ALL:
            begin
                s.elapsed = '0;
                s.pin     = ~s.pin;
            end
            default:
            begin
                s.starting = 1'b0;
                s.pin      = ~s.pin;
            end
        endcase
        return s;
    endfunction

    function automatic mtw_pkg::out_item_t watchdog_status(wd_state_t s);
        mtw_pkg::out_item_t o;
        o.pin_level     = s.pin;
        o.reset_request = s.latched;
        o.reset_cause   = s.cause;
        o.expired_task  = s.expired;
        return o;
    endfunction

    task automatic plan_item(mtw_pkg::req_t rq, logic [mtw_pkg::TASK_ID_W-1:0] tid);
        mtw_pkg::in_item_t it;
        it.req_type = rq;
        it.task_id  = tid;
        plan_model  = watchdog_next(plan_model, it);
        req_queue.push_back(it);
    endtask

    // Queue a tick; unless a latch is wanted, kick whichever task would
    // expire at the check this tick triggers.
    task automatic plan_tick(bit may_latch);
        mtw_pkg::in_item_t tick;
        wd_state_t         probe;
        tick.req_type = mtw_pkg::REQ_TICK;
        tick.task_id  = mtw_pkg::TASK_ID_W'($urandom);
        probe = watchdog_next(plan_model, tick);
        while (!may_latch && !plan_model.latched && probe.latched &&
               probe.cause == mtw_pkg::CAUSE_TASK &&
               plan_model.elapsed[probe.expired] != '0)
        begin
            plan_item(mtw_pkg::REQ_KICK_ONE, probe.expired);
            probe = watchdog_next(plan_model, tick);
        end
        plan_item(mtw_pkg::REQ_TICK, tick.task_id);
    endtask

    task automatic plan_random(int n, bit keep_alive, bit with_done);
        int k;
        int r;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                plan_tick(!keep_alive);
            else if (r < 80)
                plan_item(mtw_pkg::REQ_KICK_ONE, mtw_pkg::TASK_ID_W'($urandom));
            else if (r < 90)
                plan_item(mtw_pkg::REQ_KICK_ALL, mtw_pkg::TASK_ID_W'($urandom));
            else if (with_done)
                plan_item(mtw_pkg::REQ_START_DONE, mtw_pkg::TASK_ID_W'($urandom));
            else
                plan_tick(!keep_alive);
        end
    endtask

    task automatic settle();
        while (req_queue.size() != 0 || in_valid || status_queue.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_register(logic [mtw_pkg::CFG_IDX_W-1:0] idx,
                                  logic [mtw_pkg::CFG_DAT_W-1:0] val);
        plan_model = apply_register(plan_model, idx, val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_taken = 1'b0;
        cfg_valid <= 1'b0;
    endtask

    // request driver
    always @(negedge clk)
    begin : feed
        logic              nxt_valid;
        mtw_pkg::in_item_t nxt_item;
        nxt_valid = in_valid;
        nxt_item  = in_item;
        if (in_taken)
        begin
            nxt_valid = 1'b0;
            in_taken  = 1'b0;
        end
        if (rst_n && !nxt_valid)
        begin
            if (in_gap != 0 && !quiet)
                in_gap--;
            else if (req_queue.size() != 0)
            begin
                nxt_item  = req_queue.pop_front();
                nxt_valid = 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    in_gap = $urandom_range(1, 8);
            end
        end
        in_valid <= nxt_valid;
        in_item  <= nxt_item;
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (quiet || !rst_n)
            out_ready <= 1'b1;
        else if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 8) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : watch
        mtw_pkg::out_item_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                dut_model = apply_register(dut_model, cfg_index, cfg_data);
                cfg_taken = 1'b1;
            end
            // results first: a result never belongs to the item taken this edge
            if (out_valid && out_ready)
            begin
                if (status_queue.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected status item: pin %0b req %0b cause %0d task %0d",
                                 out_item.pin_level, out_item.reset_request,
                                 out_item.reset_cause, out_item.expired_task);
                end
                else
                begin
                    want = status_queue.pop_front();
                    if (out_item.pin_level !== want.pin_level ||
                        out_item.reset_request !== want.reset_request ||
                        out_item.reset_cause !== want.reset_cause ||
                        out_item.expired_task !== want.expired_task)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("status mismatch: exp pin %0b req %0b cause %0d task %0d",
                                     want.pin_level, want.reset_request,
                                     want.reset_cause, want.expired_task);
                            $display("                 got pin %0b req %0b cause %0d task %0d",
                                     out_item.pin_level, out_item.reset_request,
                                     out_item.reset_cause, out_item.expired_task);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                dut_model = watchdog_next(dut_model, in_item);
                status_queue.push_back(watchdog_status(dut_model));
                in_taken = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multi_task_watchdog_top test failed");
            $finish;
        end
    end

    initial
    begin
        dut_model  = watchdog_reset();
        plan_model = watchdog_reset();
        ending     = ending_t'($urandom_range(0, 2));
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extreme task ids, every kick, register edges
        plan_item(mtw_pkg::REQ_KICK_ONE, mtw_pkg::TASK_ID_W'(0));
        plan_item(mtw_pkg::REQ_KICK_ONE, mtw_pkg::TASK_ID_W'(mtw_pkg::NUM_TASKS - 1));
        plan_item(mtw_pkg::REQ_KICK_ALL, mtw_pkg::TASK_ID_W'(5));
        repeat (4) plan_tick(1'b0);
        settle();
        write_register(mtw_pkg::CFG_CHECK_PERIOD, mtw_pkg::CFG_DAT_W'(1));
        write_register(REG_SPARE, mtw_pkg::CNT_MAX);
        // startup time equal to the limit must not trip (strict compare)
        write_register(mtw_pkg::CFG_STARTUP_TIMEOUT,
                       plan_model.start_el + mtw_pkg::CNT_W'(3));
        repeat (3) plan_tick(1'b1);
        settle();
        write_register(mtw_pkg::CFG_CHECK_PERIOD, mtw_pkg::CFG_DAT_W'(0));
        write_register(mtw_pkg::CFG_STARTUP_TIMEOUT, mtw_pkg::CNT_MAX);
        write_register(mtw_pkg::CFG_TASK_TIMEOUT, mtw_pkg::CNT_MAX);
        repeat (3) plan_tick(1'b0);
        plan_item(mtw_pkg::REQ_KICK_ONE, mtw_pkg::TASK_ID_W'(2));
        settle();

        if (ending == END_STARTUP)
        begin
            write_register(mtw_pkg::CFG_CHECK_PERIOD,
                           mtw_pkg::CFG_DAT_W'($urandom_range(1, 6)));
            write_register(mtw_pkg::CFG_TASK_TIMEOUT,
                           mtw_pkg::CFG_DAT_W'($urandom_range(2, 40)));
            plan_random(150, 1'b1, 1'b0);
            settle();
            write_register(mtw_pkg::CFG_CHECK_PERIOD, mtw_pkg::CFG_DAT_W'(16'hFFFF));
            plan_random(130, 1'b1, 1'b0);
            settle();
            write_register(mtw_pkg::CFG_CHECK_PERIOD, mtw_pkg::CFG_DAT_W'(1));
            write_register(mtw_pkg::CFG_STARTUP_TIMEOUT,
                           plan_model.start_el + mtw_pkg::CNT_W'($urandom_range(0, 4)));
            while (!plan_model.latched)
                plan_tick(1'b1);
            settle();
            write_register(mtw_pkg::CFG_TASK_TIMEOUT, mtw_pkg::CFG_DAT_W'(0));
            write_register(mtw_pkg::CFG_STARTUP_TIMEOUT, mtw_pkg::CFG_DAT_W'(1));
            plan_random(150, 1'b0, 1'b1);
        end
        else
        begin
            write_register(mtw_pkg::CFG_CHECK_PERIOD,
                           mtw_pkg::CFG_DAT_W'($urandom_range(2, 6)));
            plan_random(100, 1'b1, 1'b0);
            plan_item(mtw_pkg::REQ_START_DONE, mtw_pkg::TASK_ID_W'($urandom));
            settle();
            write_register(mtw_pkg::CFG_CHECK_PERIOD, mtw_pkg::CFG_DAT_W'(1));
            write_register(mtw_pkg::CFG_TASK_TIMEOUT,
                           mtw_pkg::CFG_DAT_W'($urandom_range(2, 30)));
            plan_random(110, 1'b1, 1'b1);
            settle();
            write_register(mtw_pkg::CFG_CHECK_PERIOD,
                           mtw_pkg::CFG_DAT_W'($urandom_range(2, 12)));
            write_register(mtw_pkg::CFG_TASK_TIMEOUT,
                           mtw_pkg::CFG_DAT_W'($urandom_range(2, 200)));
            plan_random(110, 1'b1, 1'b1);
            settle();
            write_register(mtw_pkg::CFG_CHECK_PERIOD, mtw_pkg::CFG_DAT_W'(16'hFFFF));
            write_register(mtw_pkg::CFG_TASK_TIMEOUT, mtw_pkg::CFG_DAT_W'(2));
            plan_random(60, 1'b1, 1'b1);
            settle();
            write_register(mtw_pkg::CFG_CHECK_PERIOD,
                           mtw_pkg::CFG_DAT_W'($urandom_range(1, 4)));
            if (ending == END_TASK_HIT)
            begin
                // let tasks lapse; scattered kicks move the lowest expired index
                write_register(mtw_pkg::CFG_TASK_TIMEOUT,
                               mtw_pkg::CFG_DAT_W'($urandom_range(2, 24)));
                plan_item(mtw_pkg::REQ_KICK_ALL, mtw_pkg::TASK_ID_W'($urandom));
                while (!plan_model.latched)
                begin
                    if ($urandom_range(0, 3) == 0)
                        plan_item(mtw_pkg::REQ_KICK_ONE, mtw_pkg::TASK_ID_W'($urandom));
                    else
                        plan_tick(1'b1);
                end
            end
            else
            begin
                write_register(mtw_pkg::CFG_TASK_TIMEOUT, mtw_pkg::CFG_DAT_W'(0));
                while (!plan_model.latched)
                    plan_tick(1'b1);
            end
            settle();
            write_register(mtw_pkg::CFG_TASK_TIMEOUT, mtw_pkg::CFG_DAT_W'(1));
            write_register(mtw_pkg::CFG_STARTUP_TIMEOUT, mtw_pkg::CFG_DAT_W'(1));
            plan_random(100, 1'b0, 1'b1);
        end

        // closing stretch runs without gaps or stalls
        settle();
        quiet = 1'b1;
        plan_random(60, 1'b0, 1'b1);
        settle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("multi_task_watchdog_top test passed");
        else
            $display("multi_task_watchdog_top test failed");
        $finish;
    end

endmodule

### sim.f
rtl/mtw_pkg.sv
rtl/mtw_task_cell.sv
rtl/multi_task_watchdog_top.sv
sim/tb_top.sv
